@@ hdl/two_link_inverse_kinematics_core_defines.svh @@
// Assertion macros for the two-link inverse kinematics core
`ifndef TWO_LINK_INVERSE_KINEMATICS_CORE_DEFINES_SVH
`define TWO_LINK_INVERSE_KINEMATICS_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLIK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLIK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tlik_pkg.sv @@
// Types, constants and arctangent table for the inverse kinematics core
`timescale 1ns / 1ps
package tlik_pkg;
	localparam int XW   = 16;
	localparam int LW   = 14;
	localparam int NW   = 34;
	localparam int DW   = 29;
	localparam int SQW  = 58;
	localparam int RW   = 59;
	localparam int VW   = 64;
	localparam int CXW  = 34;
	localparam int ZW   = 26;
	localparam int PW   = 48;
	localparam int SQRT_STEPS = 29;
	localparam int SQRT_TOP   = 56;
	localparam int NORM_STEPS = 6;

	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	localparam logic [LW-1:0] UPPER_RST = 14'd4800;
	localparam logic [LW-1:0] LOWER_RST = 14'd3200;

	localparam logic signed [ZW-1:0] Z180 = 26'sd11796480;

	typedef struct packed {
		logic                    valid;
		logic                    unr;
		logic signed [XW-1:0]    x;
		logic signed [XW-1:0]    y;
		logic signed [NW-1:0]    num;
		logic [DW-1:0]           den;
		logic [LW-1:0]           l1;
		logic [LW-1:0]           l2;
	} side_t;

	typedef struct packed {
		logic valid;
		logic unr;
	} tag_t;

	typedef struct packed {
		logic nx;
		logic ny;
		logic zero;
	} quad_t;

	typedef struct packed {
		logic signed [CXW-1:0] cx;
		logic signed [CXW-1:0] cy;
		logic signed [ZW-1:0]  z;
		quad_t                 q;
	} cst_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
		logic signed [ZW-1:0] e;
		case (i)
			0:  e = 26'sd2949120;
			1:  e = 26'sd1740967;
			2:  e = 26'sd919879;
			3:  e = 26'sd466945;
			4:  e = 26'sd234379;
			5:  e = 26'sd117304;
			6:  e = 26'sd58666;
			7:  e = 26'sd29335;
			8:  e = 26'sd14668;
			9:  e = 26'sd7334;
			10: e = 26'sd3667;
			11: e = 26'sd1833;
			12: e = 26'sd917;
			13: e = 26'sd458;
			14: e = 26'sd229;
			15: e = 26'sd115;
			16: e = 26'sd57;
			17: e = 26'sd29;
			18: e = 26'sd14;
			19: e = 26'sd7;
			20: e = 26'sd4;
			21: e = 26'sd2;
			22: e = 26'sd1;
			default: e = '0;
		endcase
		return e;
	endfunction
endpackage

@@ hdl/tlik_sqrt_cell.sv @@
// One digit step of the pipelined integer square root
`timescale 1ns / 1ps
module tlik_sqrt_cell #(
	parameter int BIT_POS = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  tlik_pkg::side_t          side_in,
	input  logic [tlik_pkg::SQW-1:0] v_in,
	input  logic [tlik_pkg::RW-1:0]  r_in,
	output tlik_pkg::side_t          side_q,
	output logic [tlik_pkg::SQW-1:0] v_q,
	output logic [tlik_pkg::RW-1:0]  r_q
);
	import tlik_pkg::*;

	localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << BIT_POS;

	logic [RW-1:0]  trial;
	logic           ge;
	logic [SQW-1:0] v_nx;
	logic [RW-1:0]  r_nx;

	always_comb begin
		trial = r_in + BIT;
		ge    = {1'b0, v_in} >= trial;
		v_nx  = ge ? v_in - trial[SQW-1:0] : v_in;
		r_nx  = ge ? (r_in >> 1) + BIT : r_in >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_q <= v_nx;
			r_q <= r_nx;
		end
	end
endmodule

@@ hdl/tlik_cordic_cell.sv @@
// One vectoring rotation of the CORDIC arctangent chain
`timescale 1ns / 1ps
module tlik_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           en,
	input  tlik_pkg::cst_t st_in,
	output tlik_pkg::cst_t st_q
);
	import tlik_pkg::*;

	localparam logic signed [ZW-1:0] ANG = atan_entry(IDX);

	logic signed [CXW-1:0] dx;
	logic signed [CXW-1:0] dy;
	cst_t                  st_nx;

	always_comb begin
		dx    = st_in.cy >>> IDX;
		dy    = st_in.cx >>> IDX;
		st_nx = st_in;
		if (st_in.cy > 0) begin
			st_nx.cx = st_in.cx + dx;
			st_nx.cy = st_in.cy - dy;
			st_nx.z  = st_in.z + ANG;
		end else begin
			st_nx.cx = st_in.cx - dx;
			st_nx.cy = st_in.cy + dy;
			st_nx.z  = st_in.z - ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= st_nx;
		end
	end
endmodule

@@ hdl/tlik_atan2.sv @@
// Pipelined atan2: magnitude, normalize, CORDIC cell chain, quadrant fix
`timescale 1ns / 1ps
module tlik_atan2 #(
	parameter int STAGES = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [tlik_pkg::VW-1:0] y_in,
	input  logic signed [tlik_pkg::VW-1:0] x_in,
	output logic signed [tlik_pkg::ZW-1:0] z_q
);
	import tlik_pkg::*;

	logic [VW-1:0] mx [0:NORM_STEPS];
	logic [VW-1:0] my [0:NORM_STEPS];
	quad_t         qf [0:NORM_STEPS];
	cst_t          cs [0:STAGES];
	logic signed [ZW-1:0] zf;

	always_ff @(posedge clk) begin
		if (en) begin
			mx[0] <= x_in[VW-1] ? VW'(-x_in) : VW'(x_in);
			my[0] <= y_in[VW-1] ? VW'(-y_in) : VW'(y_in);
			qf[0] <= '{nx: x_in[VW-1], ny: y_in[VW-1],
				zero: (x_in == '0) && (y_in == '0)};
		end
	end

	// shift left until the leading one of either magnitude sits in the top bit
	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int K = 32 >> j;
		logic [VW-1:0] both;
		logic          sh;
		assign both = mx[j] | my[j];
		assign sh   = both[VW-1 -: K] == '0;
		always_ff @(posedge clk) begin
			if (en) begin
				mx[j+1] <= sh ? mx[j] << K : mx[j];
				my[j+1] <= sh ? my[j] << K : my[j];
				qf[j+1] <= qf[j];
			end
		end
	end

	assign cs[0].cx = $signed(CXW'(mx[NORM_STEPS][VW-1 -: 30]));
	assign cs[0].cy = $signed(CXW'(my[NORM_STEPS][VW-1 -: 30]));
	assign cs[0].z  = '0;
	assign cs[0].q  = qf[NORM_STEPS];

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		tlik_cordic_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.en    (en),
			.st_in (cs[i]),
			.st_q  (cs[i+1])
		);
	end

	always_comb begin
		zf = cs[STAGES].z;
		if (cs[STAGES].q.nx) begin
			zf = Z180 - zf;
		end
		if (cs[STAGES].q.ny) begin
			zf = -zf;
		end
		if (cs[STAGES].q.zero) begin
			zf = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_q <= zf;
		end
	end
endmodule

@@ hdl/two_link_inverse_kinematics_core.sv @@
// Path from input transfer to result: the front stages, then the 29-cell square root chain,
// then the three CORDIC cell chains run side by side, then the output register.
// Throughput: one point per cycle; the whole pipeline holds only while a result waits.
// Reset: arst_n clears all valid flags and loads link lengths 4800 and 3200.
`timescale 1ns / 1ps
`include "two_link_inverse_kinematics_core_defines.svh"
module two_link_inverse_kinematics_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [tlik_pkg::LW-1:0]       cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [tlik_pkg::XW-1:0] target_x,
	input  logic signed [tlik_pkg::XW-1:0] target_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [16:0]            shoulder_angle,
	output logic signed [15:0]            elbow_angle,
	output logic                          unreachable
);
	import tlik_pkg::*;

	localparam int ATAN_LAT = CORDIC_STAGES + 8;

	logic          en;
	logic [LW-1:0] l1_q;
	logic [LW-1:0] l2_q;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	side_t side_s1_c, side_s3_c, side_s4_c;

	logic signed [31:0]  xx_s2, yy_s2;
	logic [27:0]         l1sq_s2, l2sq_s2, l1l2_s2;
	logic [DW-1:0]       am_s4;
	logic [SQW-1:0]      dd_s5, aa_s5, rad_s6;
	logic [DW-1:0]       s_s7, s_s8;
	logic [42:0]         l2s_s7, l1den_s7;
	logic signed [PW-1:0] l2num_s7, p3x_s8, p3y_s8;

	logic signed [NW-1:0] num_c;
	logic [NW-1:0]        anum_c;
	logic                 unr_c;

	side_t          sq_side [0:SQRT_STEPS];
	logic [SQW-1:0] sq_v    [0:SQRT_STEPS];
	logic [RW-1:0]  sq_r    [0:SQRT_STEPS];
	logic [DW-1:0]  s_c;

	tag_t tag_d [0:ATAN_LAT];

	logic signed [ZW-1:0] a1, a2, a3;
	logic signed [ZW:0]   sh_v, el_v;
	logic signed [ZW:0]   sh_r, el_r;
	logic signed [16:0]   sh_c;
	logic signed [15:0]   el_c;
	logic                 out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= UPPER_RST;
			l2_q <= LOWER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UPPER: l1_q <= cfg_data;
				REG_LOWER: l2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front stages: squares, cosine numerator and denominator, reach check
	always_comb begin
		num_c  = $signed(NW'(xx_s2)) + $signed(NW'(yy_s2))
			- $signed(NW'(l1sq_s2)) - $signed(NW'(l2sq_s2));
		anum_c = side_s3.num[NW-1] ? NW'(-side_s3.num) : NW'(side_s3.num);
		unr_c  = (side_s3.l1 == '0) || (side_s3.l2 == '0) || (anum_c > NW'(side_s3.den));
		side_s1_c       = '0;
		side_s1_c.valid = in_valid;
		side_s1_c.x     = target_x;
		side_s1_c.y     = target_y;
		side_s1_c.l1    = l1_q;
		side_s1_c.l2    = l2_q;
		side_s3_c       = side_s2;
		side_s3_c.num   = num_c;
		side_s3_c.den   = {l1l2_s2, 1'b0};
		side_s4_c       = side_s3;
		side_s4_c.unr   = unr_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
		end else if (en) begin
			side_s1 <= side_s1_c;
			side_s2 <= side_s1;
			side_s3 <= side_s3_c;
			side_s4 <= side_s4_c;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= sq_side[SQRT_STEPS];
			side_s8 <= side_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2    <= side_s1.x * side_s1.x;
			yy_s2    <= side_s1.y * side_s1.y;
			l1sq_s2  <= side_s1.l1 * side_s1.l1;
			l2sq_s2  <= side_s1.l2 * side_s1.l2;
			l1l2_s2  <= side_s1.l1 * side_s1.l2;
			am_s4    <= unr_c ? '0 : anum_c[DW-1:0];
			dd_s5    <= side_s4.den * side_s4.den;
			aa_s5    <= am_s4 * am_s4;
			rad_s6   <= dd_s5 - aa_s5;
			s_s7     <= s_c;
			l2s_s7   <= sq_side[SQRT_STEPS].l2 * s_c;
			l1den_s7 <= sq_side[SQRT_STEPS].l1 * sq_side[SQRT_STEPS].den;
			l2num_s7 <= $signed({1'b0, sq_side[SQRT_STEPS].l2}) * sq_side[SQRT_STEPS].num;
			s_s8     <= s_s7;
			p3x_s8   <= $signed(PW'(l1den_s7)) + l2num_s7;
			p3y_s8   <= -$signed(PW'(l2s_s7));
		end
	end

	// square root of den^2 - num^2, one result bit per cell
	assign sq_side[0] = side_s6;
	assign sq_v[0]    = rad_s6;
	assign sq_r[0]    = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		tlik_sqrt_cell #(.BIT_POS(SQRT_TOP - 2 * k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.side_in (sq_side[k]),
			.v_in    (sq_v[k]),
			.r_in    (sq_r[k]),
			.side_q  (sq_side[k+1]),
			.v_q     (sq_v[k+1]),
			.r_q     (sq_r[k+1])
		);
	end

	assign s_c = sq_r[SQRT_STEPS][DW-1:0];

	// three arctangents in lockstep
	tlik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_target (
		.clk  (clk),
		.en   (en),
		.y_in (VW'(side_s8.y)),
		.x_in (VW'(side_s8.x)),
		.z_q  (a1)
	);

	tlik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_elbow (
		.clk  (clk),
		.en   (en),
		.y_in ($signed(VW'(s_s8))),
		.x_in (VW'(side_s8.num)),
		.z_q  (a2)
	);

	tlik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_link (
		.clk  (clk),
		.en   (en),
		.y_in (VW'(p3y_s8)),
		.x_in (VW'(p3x_s8)),
		.z_q  (a3)
	);

	assign tag_d[0].valid = side_s8.valid;
	assign tag_d[0].unr   = side_s8.unr;

	for (genvar t = 0; t < ATAN_LAT; t++) begin : g_tag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_d[t+1] <= '0;
			end else if (en) begin
				tag_d[t+1] <= tag_d[t];
			end
		end
	end

	// 1/65536 deg to 1/128 deg, round half up, clamp
	always_comb begin
		sh_v = (ZW+1)'(a1) - (ZW+1)'(a3);
		el_v = -(ZW+1)'(a2);
		sh_r = (sh_v + 27'sd256) >>> 9;
		el_r = (el_v + 27'sd256) >>> 9;
		if (sh_r > 27'sd46080) begin
			sh_c = 17'sd46080;
		end else if (sh_r < -27'sd46080) begin
			sh_c = -17'sd46080;
		end else begin
			sh_c = sh_r[16:0];
		end
		if (el_r > 27'sd0) begin
			el_c = '0;
		end else if (el_r < -27'sd23040) begin
			el_c = -16'sd23040;
		end else begin
			el_c = el_r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tag_d[ATAN_LAT].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shoulder_angle <= tag_d[ATAN_LAT].unr ? '0 : sh_c;
			elbow_angle    <= tag_d[ATAN_LAT].unr ? '0 : el_c;
			unreachable    <= tag_d[ATAN_LAT].unr;
		end
	end

	assign out_valid = out_valid_q;

	`TLIK_ASSERT_NOW(a_unr_zero, out_valid && unreachable, shoulder_angle == '0 && elbow_angle == '0, "unreachable result with nonzero angle")
	`TLIK_ASSERT_NOW(a_elbow_sign, out_valid, elbow_angle <= 16'sd0 && elbow_angle >= -16'sd23040, "elbow angle out of range")
	`TLIK_ASSERT_NOW(a_shoulder_rng, out_valid, shoulder_angle <= 17'sd46080 && shoulder_angle >= -17'sd46080, "shoulder angle out of range")
	`TLIK_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
endmodule

@@ tb/two_link_inverse_kinematics_checker.sv @@
// Result predictor and comparator for the two-link inverse kinematics core
`timescale 1ns / 1ps
module two_link_inverse_kinematics_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [tlik_pkg::LW-1:0]       cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [tlik_pkg::XW-1:0] target_x,
	input  logic signed [tlik_pkg::XW-1:0] target_y,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [16:0]            shoulder_angle,
	input  logic signed [15:0]            elbow_angle,
	input  logic                          unreachable,
	output int                            fail_count,
	output int                            pending
);
	import tlik_pkg::*;

	typedef struct packed {
		logic signed [16:0] shoulder;
		logic signed [15:0] elbow;
		logic               unr;
	} joint_t;

	logic [LW-1:0] upper_len, lower_len;
	joint_t joint_q[$];

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint vector_angle(longint yv, longint xv);
		longint unsigned ax, ay;
		longint cx, cy, z, dx, dy;
		ax = (xv < 0) ? -xv : xv;
		ay = (yv < 0) ? -yv : yv;
		z = 0;
		if ((ax | ay) == 0)
			return 0;
		while ((ax | ay) >= (64'd1 << 30)) begin
			ax = ax >> 1;
			ay = ay >> 1;
		end
		while ((ax | ay) < (64'd1 << 29)) begin
			ax = ax << 1;
			ay = ay << 1;
		end
		cx = ax;
		cy = ay;
		for (int i = 0; i < 16; i++) begin
			dx = floor_shift(cy, i);
			dy = floor_shift(cx, i);
			if (cy > 0) begin
				cx += dx;
				cy -= dy;
				z += atan_entry(i);
			end else begin
				cx -= dx;
				cy += dy;
				z -= atan_entry(i);
			end
		end
		if (xv < 0)
			z = 64'sd11796480 - z;
		if (yv < 0)
			z = -z;
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint to_deg128(longint v, longint lo, longint hi);
		longint r;
		r = (v + 256) >>> 9;
		if (r < lo)
			r = lo;
		if (r > hi)
			r = hi;
		return r;
	endfunction

	function automatic joint_t solve_joints(longint x, longint y, longint l1, longint l2);
		joint_t j;
		longint num, den, anum, s, sh, el;
		num = x * x + y * y - l1 * l1 - l2 * l2;
		den = 2 * l1 * l2;
		anum = (num < 0) ? -num : num;
		j = '0;
		if (l1 == 0 || l2 == 0 || anum > den) begin
			j.unr = 1'b1;
			return j;
		end
		s = int_sqrt(den * den - anum * anum);
		el = -vector_angle(s, num);
		sh = vector_angle(y, x) - vector_angle(-l2 * s, l1 * den + l2 * num);
		j.shoulder = to_deg128(sh, -46080, 46080);
		j.elbow = to_deg128(el, -23040, 0);
		return j;
	endfunction

	assign pending = joint_q.size();

	always @(posedge clk or negedge arst_n) begin
		joint_t exp_j;
		if (!arst_n) begin
			upper_len <= UPPER_RST;
			lower_len <= LOWER_RST;
			fail_count <= 0;
			joint_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_UPPER)
					upper_len <= cfg_data;
				else
					lower_len <= cfg_data;
			end
			if (in_valid && in_ready)
				joint_q.push_back(solve_joints(target_x, target_y, upper_len, lower_len));
			if (out_valid && out_ready) begin
				if (joint_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result transfer: %0d %0d %0b",
							shoulder_angle, elbow_angle, unreachable);
				end else begin
					exp_j = joint_q.pop_front();
					if (exp_j.shoulder !== shoulder_angle || exp_j.elbow !== elbow_angle ||
							exp_j.unr !== unreachable) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: exp sh %0d el %0d unr %0b, got %0d %0d %0b",
								exp_j.shoulder, exp_j.elbow, exp_j.unr,
								shoulder_angle, elbow_angle, unreachable);
					end
				end
			end
		end
	end
endmodule

@@ tb/two_link_inverse_kinematics_core_tb.sv @@
// Stimulus and verdict for the two-link inverse kinematics core
`timescale 1ns / 1ps
module two_link_inverse_kinematics_core_tb;
	import tlik_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_UPPER;
	logic [LW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [XW-1:0] target_x = '0;
	logic signed [XW-1:0] target_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [16:0] shoulder_angle;
	logic signed [15:0] elbow_angle;
	logic unreachable;
	int fail_count, pending, idle_cycles;
	logic [LW-1:0] cur_l1 = UPPER_RST, cur_l2 = LOWER_RST;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	two_link_inverse_kinematics_core dut (.*);

	two_link_inverse_kinematics_checker u_checker (.*);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stall per result, sometimes none
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 7) == 0)
				wait_n = 0;
			@(negedge clk);
			if (wait_n != 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_point(input logic signed [XW-1:0] x, input logic signed [XW-1:0] y,
			input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		target_x <= x;
		target_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_lengths(input logic [LW-1:0] l1, input logic [LW-1:0] l2);
		cfg_we <= 1'b1;
		cfg_index <= REG_UPPER;
		cfg_data <= l1;
		@(negedge clk);
		cfg_index <= REG_LOWER;
		cfg_data <= l2;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_l1 = l1;
		cur_l2 = l2;
	endtask

	// points mostly in the reachable ring of the current arm
	task automatic send_random(input bit burst);
		int reach, rad, ang_x, ang_y, k;
		real th, r;
		k = $urandom_range(0, 9);
		if (k < 2) begin
			send_point(XW'($urandom), XW'($urandom), burst);
		end else begin
			reach = int'(cur_l1) + int'(cur_l2);
			rad = (cur_l1 > cur_l2) ? int'(cur_l1) - int'(cur_l2) : int'(cur_l2) - int'(cur_l1);
			r = rad + (reach - rad) * ($urandom_range(0, 1000) / 1000.0);
			th = $urandom_range(0, 62831) / 10000.0;
			ang_x = $rtoi(r * $cos(th));
			ang_y = $rtoi(r * $sin(th));
			if (ang_x > 32767) ang_x = 32767;
			if (ang_x < -32768) ang_x = -32768;
			if (ang_y > 32767) ang_y = 32767;
			if (ang_y < -32768) ang_y = -32768;
			send_point(XW'(ang_x), XW'(ang_y), burst);
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: extremes, origin, axes, edge of reach
		send_point(16'sh7fff, 16'sh7fff, 0);
		send_point(16'sh8000, 16'sh8000, 0);
		send_point(16'sh8000, 16'sh7fff, 0);
		send_point(0, 0, 0);
		send_point(8000, 0, 0);
		send_point(-8000, 0, 0);
		send_point(0, 8000, 0);
		send_point(0, -8000, 0);
		send_point(1600, 0, 0);
		send_point(1599, 0, 0);
		send_point(8001, 0, 0);
		send_point(-3000, -4000, 0);
		send_point(5000, -2000, 0);
		drain();
		write_lengths(14'd4000, 14'd4000);
		send_point(0, 0, 0);
		send_point(-8000, 0, 0);
		send_point(16'shffff, 16'sh0001, 0);
		drain();
		write_lengths(14'd0, 14'd3200);
		send_point(100, 100, 0);
		drain();
		write_lengths(14'd16383, 14'd16383);
		send_point(16'sh7fff, 16'sh7fff, 0);
		send_point(-20000, 15000, 0);
		send_point(0, 0, 0);
		drain();
		write_lengths(14'd1, 14'd1);
		send_point(1, 1, 0);
		send_point(0, 2, 0);
		send_point(0, 0, 0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_lengths(UPPER_RST, LOWER_RST);
				1: write_lengths(14'd16383, 14'd1);
				2: write_lengths(LW'($urandom_range(1, 16383)), LW'($urandom_range(1, 16383)));
				3: write_lengths(14'd1, 14'd16383);
				4: write_lengths(LW'($urandom_range(1, 2000)), LW'($urandom_range(1, 2000)));
				default: write_lengths(LW'($urandom_range(1, 16383)),
					LW'($urandom_range(1, 16383)));
			endcase
			for (int n = 0; n < 120; n++)
				send_random((n / 30) % 2 == 1);
			drain();
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
